// File: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked every clock outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: src/ffha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants of the first-fit heap allocator
// Payload words, status codes, controller command and status bundles.
// ----------------------------------------------------------------------------
package ffha_pkg;
   localparam int HEAP_BYTES_DEF      = 65536;
   localparam int ALIGN_BYTES_DEF     = 8;
   localparam int MIN_SPLIT_BYTES_DEF = 16;
   localparam int HEADER_BYTES_DEF    = 16;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OOM  = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;

   typedef struct packed {
      logic        operation;
      logic [15:0] request_bytes;
      logic [15:0] release_offset;
   } req_word_type;

   typedef struct packed {
      logic [15:0] payload_offset;
      logic [1:0]  status;
   } rsp_word_type;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      DC_NONE   = 4'd0,
      DC_LOAD   = 4'd1,   // latch request, cur = 0
      DC_INIT   = 4'd2,   // write initial free block
      DC_RDCUR  = 4'd3,   // read header at cur
      DC_ADV    = 4'd4,   // cur = next of cur
      DC_WRSPL  = 4'd5,   // write split-off block
      DC_RDAFT  = 4'd6,   // read header at an after address
      DC_WRAFT  = 4'd7,   // write prev of after header
      DC_WRCUR  = 4'd8,   // write cur header from working regs
      DC_RDNXT  = 4'd9,   // read header after cur
      DC_MRGNXT = 4'd10,  // absorb next into cur
      DC_RDPRV  = 4'd11,  // read header at prev
      DC_MRGPRV = 4'd12,  // absorb cur into prev, retarget to prev
      DC_MKRSP  = 4'd13,  // build response word
      DC_SPLIT  = 4'd14   // shrink cur to need, compute split block
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type  cmd;
      logic [1:0]  rsp_status;
      logic        rsp_grant;
   } dp_ctl_type;

   typedef struct packed {
      logic op_release;
      logic zero_req;
      logic null_rel;
      logic fits;
      logic can_split;
      logic at_target;
      logic walk_end;      // next >= heap end or next <= cur
      logic past_target;   // next > target
      logic hdr_free;
      logic aft_in_heap;
      logic nxt_in_heap;
      logic cur_zero;
      logic prev_ok;       // prev < cur
      logic rd_free;       // free mark of last read header
   } dp_sts_type;
endpackage

// File: src/first_fit_heap_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top: first-fit heap allocator with coalescing
// Address-ordered block chain in a header RAM, walked one header at a time.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel carries one word: operation, request_bytes, release_offset.
//  - rsp channel returns exactly one word per request: payload_offset, status.
//  - One request is in flight at a time; req_ready is high only when idle,
//    and the next word is taken the cycle after the response word leaves.
//  - An allocate walks the chain one header at a time: read (S_RD), wait
//    for the registered RAM data (S_WAIT), evaluate (S_EVAL). A split adds
//    the split-block write and a fix-up of the after header in the heap;
//    the first allocate after reset first writes the initial free block.
//  - A release walks to its block the same way, then marks it free and
//    merges it with the following and preceding blocks if they are free.
//  - Reset clears the controller and the heap-ready flag only; the first
//    nonzero allocate writes the initial free block, so no clearing pass.
//  - While the receiver stalls, the response word holds on rsp and no new
//    request is taken.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top #(
   parameter int HEAP_BYTES      = ffha_pkg::HEAP_BYTES_DEF,
   parameter int ALIGN_BYTES     = ffha_pkg::ALIGN_BYTES_DEF,
   parameter int MIN_SPLIT_BYTES = ffha_pkg::MIN_SPLIT_BYTES_DEF,
   parameter int HEADER_BYTES    = ffha_pkg::HEADER_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ffha_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ffha_pkg::rsp_word_type rsp_word
);
   ffha_pkg::dp_ctl_type ctl;
   ffha_pkg::dp_sts_type sts;

   // Sequence the walk and own both handshakes.
   ffha_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .sts(sts), .ctl(ctl)
   );

   // Hold the header store and the block arithmetic.
   ffha_datapath #(
      .HEAP_BYTES(HEAP_BYTES), .ALIGN_BYTES(ALIGN_BYTES),
      .MIN_SPLIT_BYTES(MIN_SPLIT_BYTES), .HEADER_BYTES(HEADER_BYTES)
   ) u_dp (
      .clock(clock), .req_word(req_word), .ctl(ctl), .sts(sts),
      .rsp_word(rsp_word)
   );
endmodule

// File: src/ffha_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ram: generic single-port RAM
// One address per cycle, an optional write plus a read, registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[addr] <= wr_data;
      rd_data <= mem_ff[addr];
   end
endmodule

// File: src/ffha_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_datapath: header store, walk pointer and block arithmetic
// Executes one controller command per cycle on the header RAM.
// ----------------------------------------------------------------------------
module ffha_datapath #(
   parameter int HEAP_BYTES      = ffha_pkg::HEAP_BYTES_DEF,
   parameter int ALIGN_BYTES     = ffha_pkg::ALIGN_BYTES_DEF,
   parameter int MIN_SPLIT_BYTES = ffha_pkg::MIN_SPLIT_BYTES_DEF,
   parameter int HEADER_BYTES    = ffha_pkg::HEADER_BYTES_DEF
) (
   input  logic                  clock,
   input  ffha_pkg::req_word_type req_word,
   input  ffha_pkg::dp_ctl_type  ctl,
   output ffha_pkg::dp_sts_type  sts,
   output ffha_pkg::rsp_word_type rsp_word
);
   localparam int DEPTH = HEAP_BYTES / ALIGN_BYTES;
   localparam int AW    = $clog2(DEPTH);
   localparam int OW    = $clog2(HEAP_BYTES) + 2;   // offsets and sums
   localparam int SW    = $clog2(HEAP_BYTES) + 1;   // size field
   localparam int HW    = SW + 1 + OW;
   localparam int SHIFT = $clog2(ALIGN_BYTES);
   localparam logic [OW-1:0] HEAP_END = OW'(HEAP_BYTES);
   localparam logic [OW-1:0] HDR      = OW'(HEADER_BYTES);
   localparam logic [OW-1:0] SPLIT_MIN = OW'(HEADER_BYTES + MIN_SPLIT_BYTES);

   logic [OW-1:0] cur_ff, cur_in, tgt_ff, tgt_in, need_ff, need_in;
   logic [OW-1:0] size_ff, size_in, prev_ff, prev_in, aux_ff, aux_in;
   logic [OW-1:0] rdsize_ff, rdsize_in, nb_ff, nb_in;
   logic          op_ff, op_in, zero_ff, zero_in, null_ff, null_in;
   ffha_pkg::rsp_word_type rsp_ff, rsp_in;

   logic          wr_en;
   logic [OW-1:0] addr_off;
   logic [HW-1:0] wr_data, rd_data;
   logic [SW-1:0] rd_size;
   logic          rd_free;
   logic [OW-1:0] rd_prev;
   logic [OW-1:0] next_cur;
   logic [AW-1:0] ram_addr;

   // Pending-read flags: while one is set, the registered RAM data holds the header fields to capture.
   logic rd_pend_ff, rd_pend_in;
   logic rd_aft_ff, rd_aft_in;
   logic aftfree_ff;

   assign rd_size = rd_data[HW-1 -: SW];
   assign rd_free = rd_data[OW];
   assign rd_prev = rd_data[OW-1:0];
   assign next_cur = cur_ff + HDR + size_ff;

   // Out-of-range offsets fold to slot 0 like the block chain expects.
   always_comb begin
      if (addr_off < HEAP_END) ram_addr = AW'(addr_off >> SHIFT);
      else ram_addr = '0;
   end

   ffha_ram #(.WIDTH(HW), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .addr(ram_addr),
      .wr_data(wr_data), .rd_data(rd_data)
   );

   always_comb begin
      cur_in = cur_ff; tgt_in = tgt_ff; need_in = need_ff; size_in = size_ff;
      prev_in = prev_ff; aux_in = aux_ff; nb_in = nb_ff; rdsize_in = rdsize_ff;
      op_in = op_ff; zero_in = zero_ff; null_in = null_ff; rsp_in = rsp_ff;
      wr_en = 1'b0; addr_off = cur_ff; wr_data = '0;
      unique case (ctl.cmd)
         ffha_pkg::DC_LOAD: begin
            op_in   = req_word.operation;
            zero_in = (req_word.request_bytes == '0);
            null_in = (req_word.release_offset < 16'(HEADER_BYTES));
            need_in = ((OW'(req_word.request_bytes) + OW'(ALIGN_BYTES - 1)) >> SHIFT)
                      << SHIFT;
            tgt_in  = OW'(req_word.release_offset) - HDR;
            cur_in  = '0;
         end
         ffha_pkg::DC_INIT: begin
            wr_en = 1'b1; addr_off = '0;
            wr_data = {SW'(HEAP_BYTES - HEADER_BYTES), 1'b1, OW'(0)};
         end
         ffha_pkg::DC_RDCUR: addr_off = cur_ff;
         ffha_pkg::DC_ADV: cur_in = next_cur;
         ffha_pkg::DC_SPLIT: begin
            aux_in  = next_cur;                 // old after block
            nb_in   = cur_ff + HDR + need_ff;
            wr_en   = 1'b1; addr_off = cur_ff + HDR + need_ff;
            wr_data = {SW'(size_ff - need_ff - HDR), 1'b1, cur_ff};
            size_in = need_ff;
         end
         ffha_pkg::DC_RDAFT: addr_off = aux_ff;
         ffha_pkg::DC_WRAFT: begin
            // Point the after block back at the split-off block or the merged one.
            wr_en = 1'b1; addr_off = aux_ff;
            wr_data = {SW'(rdsize_ff), aftfree_ff, op_ff ? cur_ff : nb_ff};
         end
         ffha_pkg::DC_WRCUR: begin
            wr_en = 1'b1; addr_off = cur_ff;
            wr_data = {SW'(size_ff), op_ff, prev_ff};
         end
         ffha_pkg::DC_RDNXT: addr_off = next_cur;
         ffha_pkg::DC_MRGNXT: begin
            size_in = size_ff + HDR + OW'(rd_size);
            aux_in  = size_ff + HDR + OW'(rd_size) + cur_ff + HDR;
         end
         ffha_pkg::DC_RDPRV: addr_off = prev_ff;
         ffha_pkg::DC_MRGPRV: begin
            size_in = OW'(rd_size) + HDR + size_ff;
            aux_in  = prev_ff + HDR + OW'(rd_size) + HDR + size_ff;
            cur_in  = prev_ff;
            prev_in = rd_prev;
         end
         ffha_pkg::DC_MKRSP: begin
            rsp_in.status = ctl.rsp_status;
            rsp_in.payload_offset = ctl.rsp_grant ? 16'(cur_ff + HDR) : 16'd0;
         end
         default: ;
      endcase
   end

   assign rd_pend_in = (ctl.cmd == ffha_pkg::DC_RDCUR);
   assign rd_aft_in  = (ctl.cmd == ffha_pkg::DC_RDAFT);

   always_ff @(posedge clock) begin
      cur_ff <= cur_in; tgt_ff <= tgt_in; need_ff <= need_in; nb_ff <= nb_in;
      aux_ff <= aux_in; op_ff <= op_in; zero_ff <= zero_in; null_ff <= null_in;
      rsp_ff <= rsp_in; rd_pend_ff <= rd_pend_in; rd_aft_ff <= rd_aft_in;
      rdsize_ff <= rd_aft_ff ? OW'(rd_size) : rdsize_in;
      aftfree_ff <= rd_aft_ff ? rd_free : aftfree_ff;
      if (rd_pend_ff) begin
         size_ff <= OW'(rd_size);
         prev_ff <= rd_prev;
      end else if (ctl.cmd == ffha_pkg::DC_WRAFT) begin
         size_ff <= size_in;
         prev_ff <= prev_in;
      end else begin
         size_ff <= size_in;
         prev_ff <= prev_in;
      end
   end

   assign sts.op_release  = op_ff;
   assign sts.zero_req    = zero_ff;
   assign sts.null_rel    = null_ff;
   assign sts.hdr_free    = rd_free;
   assign sts.rd_free     = rd_free;
   assign sts.fits        = rd_free && (OW'(rd_size) >= need_ff);
   assign sts.can_split   = OW'(rd_size) >= need_ff + SPLIT_MIN;
   assign sts.at_target   = (cur_ff == tgt_ff);
   assign sts.walk_end    = (next_cur >= HEAP_END) || (next_cur <= cur_ff);
   assign sts.past_target = (next_cur > tgt_ff);
   assign sts.aft_in_heap = (aux_ff < HEAP_END);
   assign sts.nxt_in_heap = (next_cur < HEAP_END);
   assign sts.cur_zero    = (cur_ff == '0);
   assign sts.prev_ok     = (prev_ff < cur_ff);
   assign rsp_word = rsp_ff;
endmodule

// File: src/ffha_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ctrl: sequencer for allocate and release walks
// Owns the handshakes, the heap-ready flag and the command stream.
// ----------------------------------------------------------------------------
module ffha_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ffha_pkg::dp_sts_type sts,
   output ffha_pkg::dp_ctl_type ctl
);
   typedef enum logic [16:0] {
      S_IDLE  = 17'h00001, S_DEC   = 17'h00002, S_INIT  = 17'h00004,
      S_RD    = 17'h00008, S_WAIT  = 17'h00010, S_EVAL  = 17'h00020,
      S_SPLIT = 17'h00040, S_RDAFT = 17'h00080, S_WTAFT = 17'h00100,
      S_WRAFT = 17'h00200, S_WRCUR = 17'h00400, S_RSP   = 17'h00800,
      S_RDNXT = 17'h01000, S_WTNXT = 17'h02000, S_RDPRV = 17'h04000,
      S_WTPRV = 17'h08000, S_OUT   = 17'h10000
   } state_type;

   // Phase of a walk once the cur header is written: allocate, release before
   // the forward merge, after the forward merge, after the backward merge.
   typedef enum logic [3:0] {
      PH_ALLOC = 4'b0001, PH_NEXT = 4'b0010, PH_PREV = 4'b0100, PH_DONE = 4'b1000
   } phase_type;

   state_type state_ff, state_in;
   state_type aft_next;
   phase_type phase_ff, phase_in;
   logic ready_ff, ready_in;
   logic [1:0] st_ff, st_in;
   logic grant_ff, grant_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff; phase_in = phase_ff; ready_in = ready_ff;
      st_in = st_ff; grant_in = grant_ff;
      ctl.cmd = ffha_pkg::DC_NONE;
      ctl.rsp_status = st_ff; ctl.rsp_grant = grant_ff;
      // Where to go once the after block is settled.
      if (phase_ff == PH_ALLOC) aft_next = S_WRCUR;
      else if (phase_ff == PH_DONE) aft_next = S_RSP;
      else aft_next = S_RDPRV;
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            ctl.cmd = ffha_pkg::DC_LOAD; state_in = S_DEC;
         end
         S_DEC: begin
            st_in = ffha_pkg::ST_OK; grant_in = 1'b0;
            if (!sts.op_release) begin
               phase_in = PH_ALLOC;
               if (sts.zero_req) begin
                  st_in = ffha_pkg::ST_ZERO; state_in = S_RSP;
               end else if (!ready_ff) state_in = S_INIT;
               else state_in = S_RD;
            end else begin
               phase_in = PH_NEXT;
               if (sts.null_rel || !ready_ff) state_in = S_RSP;
               else state_in = S_RD;
            end
         end
         S_INIT: begin
            ctl.cmd = ffha_pkg::DC_INIT; ready_in = 1'b1; state_in = S_RD;
         end
         S_RD: begin ctl.cmd = ffha_pkg::DC_RDCUR; state_in = S_WAIT; end
         S_WAIT: state_in = S_EVAL;
         S_EVAL: begin
            if (!sts.op_release) begin
               if (sts.fits) begin
                  grant_in = 1'b1;
                  state_in = sts.can_split ? S_SPLIT : S_WRCUR;
               end else if (sts.walk_end) begin
                  st_in = ffha_pkg::ST_OOM; state_in = S_RSP;
               end else begin
                  ctl.cmd = ffha_pkg::DC_ADV; state_in = S_RD;
               end
            end else begin
               if (sts.at_target) begin
                  state_in = sts.hdr_free ? S_RSP : S_WRCUR;
               end else if (sts.past_target || sts.walk_end) state_in = S_RSP;
               else begin
                  ctl.cmd = ffha_pkg::DC_ADV; state_in = S_RD;
               end
            end
         end
         S_SPLIT: begin
            ctl.cmd = ffha_pkg::DC_SPLIT; state_in = S_RDAFT;
         end
         S_RDAFT: begin
            if (sts.aft_in_heap) begin
               ctl.cmd = ffha_pkg::DC_RDAFT; state_in = S_WTAFT;
            end else state_in = aft_next;
         end
         S_WTAFT: state_in = S_WRAFT;
         S_WRAFT: begin
            ctl.cmd = ffha_pkg::DC_WRAFT;
            state_in = aft_next;
         end
         S_WRCUR: begin
            ctl.cmd = ffha_pkg::DC_WRCUR;
            if (phase_ff == PH_NEXT) state_in = S_RDNXT;
            else if (phase_ff == PH_ALLOC) state_in = S_RSP;
            else state_in = S_RDAFT;
         end
         S_RDNXT: begin
            if (sts.nxt_in_heap) begin
               ctl.cmd = ffha_pkg::DC_RDNXT; state_in = S_WTNXT;
            end else state_in = S_RDPRV;
         end
         S_WTNXT: begin
            if (sts.rd_free) begin
               ctl.cmd = ffha_pkg::DC_MRGNXT; phase_in = PH_PREV; state_in = S_WRCUR;
            end else state_in = S_RDPRV;
         end
         S_RDPRV: begin
            phase_in = PH_ALLOC;
            if (!sts.cur_zero && sts.prev_ok) begin
               ctl.cmd = ffha_pkg::DC_RDPRV; state_in = S_WTPRV;
            end else state_in = S_RSP;
         end
         S_WTPRV: begin
            if (sts.rd_free) begin
               ctl.cmd = ffha_pkg::DC_MRGPRV; phase_in = PH_DONE; state_in = S_WRCUR;
            end else state_in = S_RSP;
         end
         S_RSP: begin ctl.cmd = ffha_pkg::DC_MKRSP; state_in = S_OUT; end
         S_OUT: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; phase_ff <= PH_ALLOC; ready_ff <= 1'b0;
         st_ff <= ffha_pkg::ST_OK; grant_ff <= 1'b0;
      end else begin
         state_ff <= state_in; phase_ff <= phase_in; ready_ff <= ready_in;
         st_ff <= st_in; grant_ff <= grant_in;
      end
   end
endmodule

// File: src/ffha_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_checker: port-level checks of the allocator
// One request in flight, sane responses.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ffha_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input ffha_pkg::rsp_word_type rsp_word
);
   logic rsp_failed;
   assign rsp_failed = rsp_valid && (rsp_word.status != ffha_pkg::ST_OK);

   `ASSERT_IMPL(a_one_inflight, clock, reset, rsp_valid, !req_ready)
   `ASSERT_NEXT(a_accept_closes, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_IMPL(a_status_code, clock, reset, rsp_valid, rsp_word.status <= ffha_pkg::ST_ZERO)
   `ASSERT_IMPL(a_fail_zero, clock, reset, rsp_failed, rsp_word.payload_offset == 16'd0)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))
endmodule

bind first_fit_heap_allocator_top ffha_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
);
